// ===== rtl/erd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package erd_pkg;
  localparam int unsigned PeakHistoryDef = 128;
  localparam int unsigned SampleWidthDef = 24;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 23;
  localparam logic [CfgIdxW-1:0] RegMinLevel = 1'd0;
  localparam logic [CfgIdxW-1:0] RegMissLimit = 1'd1;
  localparam logic [8:0] WinLowMul = 9'd236;
  localparam logic [8:0] WinHighMul = 9'd297;
  localparam logic [8:0] MissMul = 9'd425;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CLEAR, ST_SCAN, ST_WAIT, ST_UPDATE, ST_OUT
  } erd_state_e;

  // divide by a power of two, rounding toward zero
  function automatic logic signed [39:0] sdiv_pow2(input logic signed [39:0] v,
                                                   input int unsigned sh);
    logic signed [39:0] b;
    b = (40'sd1 <<< sh) - 40'sd1;
    sdiv_pow2 = (v < 0) ? ((v + b) >>> sh) : (v >>> sh);
  endfunction

  function automatic logic [16:0] moving_avg(input logic [16:0] avg, input logic [15:0] last,
                                             input logic [15:0] rr);
    logic [17:0] a;
    logic [17:0] s;
    a = {1'b0, avg} + {5'd0, rr[15:3]};
    s = {5'd0, last[15:3]};
    moving_avg = (a >= s) ? 17'(a - s) : 17'd0;
  endfunction
endpackage
`default_nettype wire

// ===== rtl/erd_stream_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface erd_in_if #(parameter int unsigned W = 24);
  logic valid;
  logic ready;
  logic signed [W-1:0] sample;
  modport source(output valid, sample, input ready);
  modport sink(input valid, sample, output ready);
endinterface

interface erd_out_if #(parameter int unsigned W = 24);
  logic valid;
  logic ready;
  logic rpeak_found;
  logic searchback_found;
  logic [15:0] rr_interval;
  logic signed [W-1:0] rpeak_value;
  logic low_amplitude_warn;
  logic irregular_warn;
  modport source(output valid, rpeak_found, searchback_found, rr_interval, rpeak_value,
                 low_amplitude_warn, irregular_warn, input ready);
  modport sink(input valid, rpeak_found, searchback_found, rr_interval, rpeak_value,
               low_amplitude_warn, irregular_warn, output ready);
endinterface
`default_nettype wire

// ===== rtl/erd_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module erd_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 128,
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [Width-1:0] rdata_o
);
  logic [Width-1:0] mem [Depth];

  // one write port, registered read
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

// ===== rtl/ecg_rpeak_detector.sv =====
// each input word passes ST_WAIT, ST_SCAN if searched back, then ST_UPDATE and ST_OUT
// a new input word is taken only after the result word of the last one is accepted
// reset: asynchronous, active low; levels, RR averages and registers take their defaults
// after reset the history RAM is cleared one entry a cycle, input held off
// configuration writes are taken at any time
`timescale 1ns / 1ps
`default_nettype none
module ecg_rpeak_detector import erd_pkg::*; #(
  parameter int unsigned PeakHistory = PeakHistoryDef,
  parameter int unsigned SampleWidth = SampleWidthDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  erd_in_if.sink                   in_if,
  erd_out_if.source                out_if,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);
  localparam int unsigned AW = (PeakHistory > 1) ? $clog2(PeakHistory) : 1;
  localparam int unsigned CW = $clog2(PeakHistory + 1);
  localparam logic [CW-1:0] LastCnt = CW'(PeakHistory);
  localparam logic [AW-1:0] LastIdx = AW'(PeakHistory - 1);
  typedef logic signed [SampleWidth-1:0] smp_t;

  erd_state_e state_q, state_d;
  logic [22:0] min_level_q;
  logic [7:0] miss_limit_q;
  smp_t win0_q, win1_q, pk_q;
  logic [AW-1:0] pidx_q;
  logic [CW-1:0] cnt_q;
  logic signed [39:0] sig_q, noise_q, thr_hi_q, thr_lo_q;
  logic [16:0] avg_all_q, avg_reg_q, win_lo_q;
  logic [15:0] last_all_q, last_reg_q, icnt_q, rr_q;
  logic [17:0] win_hi_q, miss_lim_q;
  logic [7:0] miss_q;
  logic hit_q, sb_q, rpk_q, irr_q;
  logic [AW-1:0] raddr;
  logic [SampleWidth-1:0] rdata;
  logic we;
  logic [AW-1:0] waddr;
  logic [SampleWidth-1:0] wdata;
  logic above, in_win;
  logic [7:0] miss_inc;
  logic [16:0] new_reg;
  logic signed [39:0] new_sig, new_noise;
  logic [25:0] p_lo, p_hi, p_ms;

  erd_ram #(.Width(SampleWidth), .Depth(PeakHistory)) u_hist (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata), .raddr_i(raddr), .rdata_o(rdata)
  );

  // classification of the incoming word
  assign above = 40'(pk_q) > thr_hi_q;
  assign in_win = (win_lo_q < {1'b0, icnt_q}) && ({2'b0, icnt_q} < win_hi_q);
  assign miss_inc = (miss_q != 8'hff) ? miss_q + 8'd1 : miss_q;
  assign raddr = cnt_q[AW-1:0];

  // history writes: clearing pass, else peak store
  always_comb begin
    we = 1'b0;
    waddr = pidx_q;
    wdata = SampleWidth'(pk_q);
    if (state_q == ST_CLEAR) begin
      we = 1'b1;
      waddr = cnt_q[AW-1:0];
      wdata = '0;
    end else if (state_q == ST_WAIT && hit_q) begin
      we = 1'b1;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR:  if (cnt_q[AW-1:0] == LastIdx) state_d = ST_IDLE;
      ST_IDLE:   if (in_if.valid) state_d = ST_WAIT;
      ST_WAIT:   state_d = (hit_q && above && !in_win && {2'b0, icnt_q} < miss_lim_q) ?
                           ST_SCAN : ST_UPDATE;
      ST_SCAN:   if (sb_q || cnt_q == LastCnt) state_d = ST_UPDATE;
      ST_UPDATE: state_d = ST_OUT;
      ST_OUT:    if (out_if.ready) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // level and window updates
  assign new_reg = moving_avg(avg_reg_q, last_reg_q, rr_q);
  assign new_sig = rpk_q ? sdiv_pow2(40'(pk_q) + 40'sd7 * sig_q, 3)
                         : sdiv_pow2(40'(pk_q) + 40'sd3 * sig_q, 2);
  assign new_noise = sdiv_pow2(40'(pk_q) + 40'sd7 * noise_q, 3);
  assign p_lo = 26'(WinLowMul) * 26'(avg_reg_q);
  assign p_hi = 26'(WinHighMul) * 26'(avg_reg_q);
  assign p_ms = 26'(MissMul) * 26'(avg_reg_q);

  // outputs
  assign in_if.ready = (state_q == ST_IDLE);
  assign out_if.valid = (state_q == ST_OUT);

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_level_q <= 23'd2000;
      miss_limit_q <= 8'd5;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegMinLevel:  min_level_q <= cfg_data_i;
        RegMissLimit: miss_limit_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // main datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      win0_q <= '0; win1_q <= '0; pk_q <= '0;
      pidx_q <= '0; cnt_q <= '0;
      sig_q <= 40'sd4500; noise_q <= 40'sd2000; thr_hi_q <= 40'sd2300; thr_lo_q <= 40'sd1300;
      avg_all_q <= 17'd150; last_all_q <= 16'd150;
      avg_reg_q <= 17'd160; last_reg_q <= 16'd160;
      win_lo_q <= 17'd120; win_hi_q <= 18'd246; miss_lim_q <= 18'd352;
      icnt_q <= '0; miss_q <= '0; rr_q <= '0;
      hit_q <= 1'b0; sb_q <= 1'b0; rpk_q <= 1'b0; irr_q <= 1'b0;
      out_if.rpeak_found <= 1'b0; out_if.searchback_found <= 1'b0;
      out_if.rr_interval <= '0; out_if.rpeak_value <= '0;
      out_if.low_amplitude_warn <= 1'b0; out_if.irregular_warn <= 1'b0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        ST_CLEAR: cnt_q <= cnt_q + CW'(1);
        ST_IDLE: if (in_if.valid) begin
          hit_q <= (win0_q < win1_q) && (win1_q > in_if.sample);
          pk_q <= win1_q;
          win0_q <= win1_q;
          win1_q <= in_if.sample;
        end
        ST_WAIT: begin
          cnt_q <= '0;
          sb_q <= 1'b0;
          rpk_q <= 1'b0;
          irr_q <= 1'b0;
          rr_q <= '0;
          if (!hit_q) pk_q <= '0;
          if (hit_q) begin
            pidx_q <= (pidx_q == LastIdx) ? '0 : pidx_q + AW'(1);
            if (above) begin
              rr_q <= icnt_q;
              icnt_q <= '0;
              if (in_win) begin
                rpk_q <= 1'b1;
              end else begin
                miss_q <= miss_inc;
                irr_q <= (miss_inc >= miss_limit_q);
              end
            end
          end
        end
        ST_SCAN: begin
          // entries arrive in the cycle after their address is given
          cnt_q <= cnt_q + CW'(1);
          if (cnt_q != '0 && 40'($signed(rdata)) > thr_lo_q) sb_q <= 1'b1;
        end
        ST_UPDATE: begin
          if (icnt_q != 16'hffff) icnt_q <= icnt_q + 16'd1;
          if (hit_q && !above) begin
            noise_q <= new_noise;
            thr_hi_q <= sdiv_pow2(40'sd3 * new_noise + sig_q, 2);
            thr_lo_q <= sdiv_pow2(sdiv_pow2(40'sd3 * new_noise + sig_q, 2), 1);
          end
          if (rpk_q || sb_q) begin
            sig_q <= new_sig;
            thr_hi_q <= sdiv_pow2(40'sd3 * noise_q + new_sig, 2);
            thr_lo_q <= sdiv_pow2(sdiv_pow2(40'sd3 * noise_q + new_sig, 2), 1);
            avg_all_q <= moving_avg(avg_all_q, last_all_q, rr_q);
            last_all_q <= rr_q;
          end
          if (rpk_q) begin
            avg_reg_q <= new_reg;
            last_reg_q <= rr_q;
            miss_q <= '0;
          end
          out_if.rpeak_found <= rpk_q;
          out_if.searchback_found <= sb_q;
          out_if.rr_interval <= rr_q;
          out_if.rpeak_value <= (rpk_q || sb_q) ? pk_q : '0;
          out_if.low_amplitude_warn <= (rpk_q || sb_q) &&
                                       (40'(pk_q) < $signed({17'd0, min_level_q}));
          out_if.irregular_warn <= irr_q;
        end
        ST_OUT: begin
          // window limits follow the regular average in the cycle after it is updated
          win_lo_q <= 17'(p_lo >> 8);
          win_hi_q <= 18'(p_hi >> 8);
          miss_lim_q <= 18'(p_ms >> 8);
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTH
  a_out_only_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> !in_if.ready) else $error("input taken while word pending");
  a_one_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> !(out_if.rpeak_found && out_if.searchback_found))
    else $error("both detection kinds flagged");
  a_thr_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT) |-> (thr_lo_q <= thr_hi_q || thr_hi_q < 0))
    else $error("low threshold above high threshold");
`endif
endmodule
`default_nettype wire
